[design/ctwm_pkg.sv]
// Shared types, constants and helper functions for the cosmic track window matcher.
`default_nettype none

package ctwm_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int FRAME_HITS_DEF   = 65536;
    localparam int NUM_PATTERNS     = 13;
    localparam int GRID_BITS        = 9;
    localparam int MID_DEPTH        = 2;
    localparam int OUT_DEPTH        = 4;

    localparam logic [15:0] WINDOW_RESET = 16'd100;

    localparam logic [GRID_BITS-1:0] TRACK_SHAPES [NUM_PATTERNS] = '{
        9'h124, 9'h092, 9'h049, 9'h111, 9'h054, 9'h112, 9'h0A4,
        9'h089, 9'h052, 9'h051, 9'h114, 9'h0A2, 9'h08A
    };

    typedef struct packed {
        logic [31:0] hit_time;
        logic [1:0]  hit_row;
        logic [1:0]  hit_col;
        logic        frame_end;
    } hit_t;

    typedef struct packed {
        logic [15:0] first_hit;
        logic [4:0]  hit_count;
        logic [3:0]  pattern_index;
        logic        overflow;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [31:0]          hit_time;
        logic [GRID_BITS-1:0] cell_bits;
        logic                 frame_end;
    } item_t;

    typedef struct packed {
        logic idle;
        logic pend_valid;
    } back_stat_t;

    // one-hot grid cell, nothing for a row or column of 3
    function automatic logic [GRID_BITS-1:0] cell_bits(input logic [1:0] row,
                                                       input logic [1:0] col);
        logic [GRID_BITS-1:0] b;
        logic [3:0]           pos;
        b   = '0;
        pos = {2'b00, row} * 4'd3 + {2'b00, col};
        if (row < 2'd3 && col < 2'd3)
        begin
            b[pos] = 1'b1;
        end
        return b;
    endfunction

    // {found, index} of the first pattern contained in the grid
    function automatic logic [4:0] match_grid(input logic [GRID_BITS-1:0] grid);
        logic       found;
        logic [3:0] idx;
        found = 1'b0;
        idx   = '0;
        for (int p = NUM_PATTERNS - 1; p >= 0; p--)
        begin
            if ((grid & TRACK_SHAPES[p]) == TRACK_SHAPES[p])
            begin
                found = 1'b1;
                idx   = 4'(p);
            end
        end
        return {found, idx};
    endfunction

endpackage

`default_nettype wire

[design/ctwm_fifo.sv]
// Small register queue used between the front and back parts and on the result side.
`default_nettype none

module ctwm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[design/ctwm_front.sv]
// Front part: accepts hits and turns row and column into a grid cell mask.
`default_nettype none

module ctwm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ctwm_pkg::hit_t hit,
    output logic                full,
    output logic                q_push,
    output ctwm_pkg::item_t     q_item,
    input  wire logic           q_full
);

    import ctwm_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  accept;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg;
    assign q_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next          = 1'b1;
            item_next.hit_time  = hit.hit_time;
            item_next.cell_bits = cell_bits(hit.hit_row, hit.hit_col);
            item_next.frame_end = hit.frame_end;
        end
        else if (valid_reg && !q_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

[design/ctwm_back.sv]
// Back part: hit buffer, window closing sequencer and pattern match.
`default_nettype none

module ctwm_back #(
    parameter int WINDOW_DEPTH = ctwm_pkg::WINDOW_DEPTH_DEF,
    parameter int FRAME_HITS   = ctwm_pkg::FRAME_HITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [15:0]     window,
    input  wire logic            q_empty,
    input  wire ctwm_pkg::item_t q_item,
    output logic                 q_pop,
    input  wire logic            out_full,
    output logic                 out_push,
    output ctwm_pkg::result_t    out_data,
    output ctwm_pkg::back_stat_t stat
);

    import ctwm_pkg::*;

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [15:0]   IDX_CAP = (FRAME_HITS - 1 > 65535) ? 16'hFFFF
                                                                 : 16'(FRAME_HITS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]           state_reg, state_next;
    item_t                item_reg, item_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [15:0]          idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    result_t              pend_reg, pend_next;

    logic [31:0]          times_reg [WINDOW_DEPTH];
    logic [GRID_BITS-1:0] grid_reg  [WINDOW_DEPTH];

    logic [31:0] elapsed;
    logic        timeout;
    logic [4:0]  match;
    result_t     cand;
    logic        close_en, close_ovf, stall_close;
    logic        do_pop, do_store;

    assign elapsed     = item_reg.hit_time - times_reg[0];
    assign timeout     = (count_reg >= CW'(2)) && (elapsed > {16'b0, window});
    assign match       = match_grid(grid_reg[0]);
    assign stall_close = match[4] && pend_valid_reg && out_full;

    always_comb
    begin
        cand.first_hit     = idx_reg;
        cand.hit_count     = 5'(count_reg);
        cand.pattern_index = match[3:0];
        cand.overflow      = close_ovf;
        cand.last_result   = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        q_pop           = 1'b0;
        out_push        = 1'b0;
        out_data        = pend_reg;
        close_en        = 1'b0;
        close_ovf       = 1'b0;
        do_pop          = 1'b0;
        do_store        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (timeout)
                begin
                    close_en = 1'b1;
                end
                else if (count_reg >= DEPTH_C)
                begin
                    close_en  = 1'b1;
                    close_ovf = 1'b1;
                end
                else
                begin
                    do_store   = 1'b1;
                    state_next = item_reg.frame_end ? S_DRAIN : S_FLUSH;
                end
            end
            S_STORE:
            begin
                do_store   = 1'b1;
                state_next = item_reg.frame_end ? S_DRAIN : S_FLUSH;
            end
            S_DRAIN:
            begin
                if (count_reg >= CW'(3))
                begin
                    close_en = 1'b1;
                end
                else
                begin
                    count_next = '0;
                    idx_next   = '0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_full)
                begin
                    out_push             = 1'b1;
                    out_data.last_result = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the oldest window closes with every buffered hit
        if (close_en && !stall_close)
        begin
            do_pop = 1'b1;
            if (match[4])
            begin
                out_push        = pend_valid_reg;
                pend_next       = cand;
                pend_valid_next = 1'b1;
            end
            if (close_ovf)
            begin
                state_next = S_STORE;
            end
        end

        if (do_pop)
        begin
            count_next = count_reg - 1'b1;
            idx_next   = (idx_reg < IDX_CAP) ? idx_reg + 16'd1 : idx_reg;
        end
        else if (do_store)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pend_reg <= pend_next;
    end

    // hit buffer, oldest at entry 0; grid_reg holds the OR of cells from that entry on
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            for (int k = 0; k < WINDOW_DEPTH - 1; k++)
            begin
                times_reg[k] <= times_reg[k + 1];
                grid_reg[k]  <= grid_reg[k + 1];
            end
        end
        else if (do_store)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++)
            begin
                if (AW'(k) == count_reg[AW-1:0])
                begin
                    times_reg[k] <= item_reg.hit_time;
                    grid_reg[k]  <= item_reg.cell_bits;
                end
                else if (CW'(k) < count_reg)
                begin
                    grid_reg[k] <= grid_reg[k] | item_reg.cell_bits;
                end
            end
        end
    end

    assign stat.idle       = (state_reg == S_IDLE);
    assign stat.pend_valid = pend_valid_reg;

endmodule

`default_nettype wire

[design/cosmic_track_window_matcher_unit.sv]
// Top level of the cosmic track window matcher: front, hit queue, back and result queue.
//
//  channel   direction  handshake           payload
//  hit       in         push / full         ctwm_pkg::hit_t
//  result    out        pop / empty         ctwm_pkg::result_t
//  window    in         window_we           window_data, 16 bit
//
// A hit passes the front register and the hit queue; the back sequencer then pops it,
// closes the windows it ends, stores it, drains the buffer at a frame end and flushes
// the pending result; it closes one window a cycle unless a full result queue holds it.
// Reset (rst_n, asynchronous) empties the buffer and queues and sets the window to 100.
// A full result queue holds the back sequencer; the hit queue then fills and raises full.
`default_nettype none

module cosmic_track_window_matcher_unit #(
    parameter int WINDOW_DEPTH = ctwm_pkg::WINDOW_DEPTH_DEF,
    parameter int FRAME_HITS   = ctwm_pkg::FRAME_HITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ctwm_pkg::hit_t    hit,
    output logic                   full,
    input  wire logic              pop,
    output ctwm_pkg::result_t      result,
    output logic                   empty,
    input  wire logic              window_we,
    input  wire logic [15:0]       window_data
);

    import ctwm_pkg::*;

    logic [15:0] window_reg, window_next;

    logic       mid_push, mid_full, mid_pop, mid_empty;
    item_t      mid_in, mid_out;
    logic [$bits(item_t)-1:0] mid_rdata;

    logic       out_push, out_full;
    result_t    out_data;
    logic [$bits(result_t)-1:0] out_rdata;
    back_stat_t stat;

    assign window_next = window_we ? window_data : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    ctwm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .hit    (hit),
        .full   (full),
        .q_push (mid_push),
        .q_item (mid_in),
        .q_full (mid_full)
    );

    ctwm_fifo #(
        .W     ($bits(item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_in),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign mid_out = item_t'(mid_rdata);

    ctwm_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .FRAME_HITS   (FRAME_HITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .window   (window_reg),
        .q_empty  (mid_empty),
        .q_item   (mid_out),
        .q_pop    (mid_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_data),
        .stat     (stat)
    );

    ctwm_fifo #(
        .W     ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign result = result_t'(out_rdata);

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        stat.idle |-> !stat.pend_valid)
        else $error("back part idle with a result still pending");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_data.last_result) |=> !stat.pend_valid)
        else $error("pending result left after the last transaction of a hit");
`endif

endmodule

`default_nettype wire
